>>> rtl/core/ccq_pkg.sv
`default_nettype none

package ccq_pkg;

  // input function codes
  localparam logic [2:0] FUNC_DATA   = 3'd0;
  localparam logic [2:0] FUNC_CMD    = 3'd1;
  localparam logic [2:0] FUNC_ADDR   = 3'd2;
  localparam logic [2:0] FUNC_NUMBER = 3'd3;
  localparam logic [2:0] FUNC_TICK   = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_NIBBLE = 2'd1;
  localparam logic [1:0] KIND_IDLE   = 2'd2;

  localparam logic [7:0]  ADDR_MARK  = 8'h80;
  localparam logic [7:0]  ASCII_ZERO = 8'h30;
  localparam logic [3:0]  RADIX      = 4'd10;
  // floor(q / 10) == (q * 52429) >> 19 for every 16-bit q
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;

  localparam int OPQ_DEPTH = 4;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] value;
    logic [2:0]  digit_count;
    logic        busy_flag;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       reg_select;
    logic [3:0] nibble;
    logic       overflow;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    OPC_PUSH,
    OPC_ACK,
    OPC_TICK,
    OPC_NONE
  } op_code_t;

  typedef struct packed {
    op_code_t   code;
    logic       rs;
    logic [7:0] data;
    logic       ends;
  } op_t;

  typedef struct packed {
    logic       rs;
    logic [7:0] data;
  } entry_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_EMIT
  } front_state_t;

  typedef enum logic [1:0] {
    B_RUN,
    B_HI,
    B_LO
  } back_state_t;

endpackage

`default_nettype wire

>>> rtl/core/ccq_front.sv
`default_nettype none

module ccq_front import ccq_pkg::*; #(
  parameter int MAX_DIGITS = 5
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  output logic          op_push,
  output op_t           op_data,
  input  wire logic     op_full
);

  localparam int CW = $clog2(MAX_DIGITS + 1);

  front_state_t state, state_next;
  logic [15:0]  q, q_next;
  logic [CW-1:0] nd, nd_next;
  logic [CW-1:0] left, left_next;
  logic [3:0]   digs [MAX_DIGITS];
  logic         shift_in, shift_out;

  logic [31:0]  prod;
  logic [15:0]  quo;
  logic [15:0]  rem_full;
  logic [3:0]   rem;
  logic [CW-1:0] n_sat;
  logic         accept;

  assign prod     = q * DIV10_MUL;
  assign quo      = 16'(prod[31:DIV10_SHIFT]);
  assign rem_full = q - ((quo << 3) + (quo << 1));
  assign rem      = rem_full[3:0];

  assign n_sat = (32'(in_item.digit_count) > 32'(MAX_DIGITS)) ? CW'(MAX_DIGITS)
                                                             : CW'(in_item.digit_count);

  assign in_stall = (state != F_IDLE) || op_full;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      left  <= '0;
      nd    <= '0;
    end else begin
      state <= state_next;
      left  <= left_next;
      nd    <= nd_next;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

  // digit shift line: new digits enter at the bottom, so the msd ends up in slot 0
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_DIGITS; k++) begin
      if (shift_in) begin
        digs[k] <= (k == 0) ? rem : digs[(k == 0) ? 0 : k - 1];
      end else if (shift_out) begin
        digs[k] <= (k == MAX_DIGITS - 1) ? 4'd0 : digs[(k == MAX_DIGITS - 1) ? k : k + 1];
      end
    end
  end

  always_comb begin
    state_next = state;
    q_next     = q;
    nd_next    = nd;
    left_next  = left;
    shift_in   = 1'b0;
    shift_out  = 1'b0;
    op_push    = 1'b0;
    op_data    = '{code: OPC_NONE, rs: 1'b0, data: 8'h00, ends: 1'b1};
    unique case (state)
      F_IDLE: begin
        if (accept) begin
          unique case (in_item.func)
            FUNC_DATA: begin
              op_push = 1'b1;
              op_data = '{code: OPC_PUSH, rs: 1'b1, data: in_item.value[7:0], ends: 1'b1};
            end
            FUNC_CMD: begin
              op_push = 1'b1;
              op_data = '{code: OPC_PUSH, rs: 1'b0, data: in_item.value[7:0], ends: 1'b1};
            end
            FUNC_ADDR: begin
              op_push = 1'b1;
              op_data = '{code: OPC_PUSH, rs: 1'b0, data: in_item.value[7:0] | ADDR_MARK,
                          ends: 1'b1};
            end
            FUNC_NUMBER: begin
              if (n_sat == '0) begin
                op_push = 1'b1;
                op_data = '{code: OPC_ACK, rs: 1'b0, data: 8'h00, ends: 1'b1};
              end else begin
                q_next     = in_item.value;
                nd_next    = n_sat;
                left_next  = n_sat;
                state_next = F_CONV;
              end
            end
            FUNC_TICK: begin
              op_push = 1'b1;
              op_data = '{code: op_code_t'(in_item.busy_flag ? OPC_NONE : OPC_TICK),
                          rs: 1'b0, data: 8'h00, ends: 1'b1};
            end
            default: begin
              op_push = 1'b1;
            end
          endcase
        end
      end
      F_CONV: begin
        // one digit per cycle, least significant first
        shift_in = 1'b1;
        q_next   = quo;
        if (left == CW'(1)) begin
          left_next  = nd;
          state_next = F_EMIT;
        end else begin
          left_next = left - 1'b1;
        end
      end
      F_EMIT: begin
        if (!op_full) begin
          op_push   = 1'b1;
          op_data   = '{code: OPC_PUSH, rs: 1'b1, data: ASCII_ZERO | {4'd0, digs[0]},
                        ends: (left == CW'(1))};
          shift_out = 1'b1;
          left_next = left - 1'b1;
          if (left == CW'(1)) begin
            state_next = F_IDLE;
          end
        end
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == F_CONV) |-> (left != '0) && (nd != '0))
    else $error("conversion running with no digits");

  assert property (@(posedge clk) disable iff (rst)
    (state == F_EMIT && $past(state) == F_CONV) |-> (left == nd))
    else $error("emit count not loaded from digit count");

  assert property (@(posedge clk) disable iff (rst)
    (op_push && op_data.code == OPC_PUSH && !op_data.ends) |-> (state == F_EMIT))
    else $error("non-final push outside number emission");

  assert property (@(posedge clk) disable iff (rst)
    (state == F_CONV) |-> (rem < RADIX))
    else $error("digit out of range");

endmodule

`default_nettype wire

>>> rtl/core/ccq_opq.sv
`default_nettype none

module ccq_opq import ccq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire op_t  push_op,
  output logic      full,
  input  wire logic pop,
  output op_t       pop_op,
  output logic      empty
);

  localparam int PW = $clog2(OPQ_DEPTH);
  localparam int NW = $clog2(OPQ_DEPTH + 1);

  op_t           slots [OPQ_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [NW-1:0] fill;
  logic          do_push, do_pop;

  assign full    = (fill == NW'(OPQ_DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_op  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + NW'(do_push) - NW'(do_pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (fill <= NW'(OPQ_DEPTH)))
    else $error("op queue fill above depth");

  assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (fill == $past(fill) + 1'b1))
    else $error("op queue fill did not track push");

  assert property (@(posedge clk) disable iff (rst)
    (fill == '0 || fill == NW'(OPQ_DEPTH)) |-> (wr_ptr == rd_ptr))
    else $error("op queue pointers out of step");

endmodule

`default_nettype wire

>>> rtl/core/ccq_back.sv
`default_nettype none

module ccq_back import ccq_pkg::*; #(
  parameter int QUEUE_DEPTH = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire op_t   op,
  input  wire logic  op_empty,
  output logic       op_pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output out_item_t  out_item
);

  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CNW = $clog2(QUEUE_DEPTH + 1);

  entry_t        mem [QUEUE_DEPTH];
  entry_t        rd_data;
  back_state_t   state, state_next;
  logic [QW-1:0] head, head_next, tail, tail_next;
  logic [CNW-1:0] count, count_next;
  logic          dropped, dropped_next;
  logic          wr_en, rd_en, load_out, out_free, q_full;
  out_item_t     out_next;

  assign out_free = !out_valid || !out_stall;
  assign q_full   = (count == CNW'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail] <= '{rs: op.rs, data: op.data};
    end
    if (rd_en) begin
      rd_data <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_RUN;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      head    <= head_next;
      tail    <= tail_next;
      count   <= count_next;
      dropped <= dropped_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item <= out_next;
    end
  end

  always_comb begin
    state_next   = state;
    head_next    = head;
    tail_next    = tail;
    count_next   = count;
    dropped_next = dropped;
    op_pop       = 1'b0;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    load_out     = 1'b0;
    out_next     = '0;
    unique case (state)
      B_RUN: begin
        if (!op_empty) begin
          unique case (op.code)
            OPC_PUSH: begin
              if (!op.ends || out_free) begin
                op_pop = 1'b1;
                if (!q_full) begin
                  wr_en      = 1'b1;
                  tail_next  = (tail == QW'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
                  count_next = count + 1'b1;
                end
                if (op.ends) begin
                  load_out     = 1'b1;
                  out_next     = '{kind: KIND_ACK, reg_select: 1'b0, nibble: 4'd0,
                                   overflow: dropped || q_full, last: 1'b1};
                  dropped_next = 1'b0;
                end else if (q_full) begin
                  dropped_next = 1'b1;
                end
              end
            end
            OPC_ACK: begin
              if (out_free) begin
                op_pop       = 1'b1;
                load_out     = 1'b1;
                out_next     = '{kind: KIND_ACK, reg_select: 1'b0, nibble: 4'd0,
                                 overflow: dropped, last: 1'b1};
                dropped_next = 1'b0;
              end
            end
            OPC_TICK: begin
              if (count != '0) begin
                // start the entry read, nibbles follow from the registered data
                op_pop     = 1'b1;
                rd_en      = 1'b1;
                head_next  = (head == QW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
                count_next = count - 1'b1;
                state_next = B_HI;
              end else if (out_free) begin
                op_pop   = 1'b1;
                load_out = 1'b1;
                out_next = '{kind: KIND_IDLE, reg_select: 1'b0, nibble: 4'd0,
                             overflow: 1'b0, last: 1'b1};
              end
            end
            OPC_NONE: begin
              if (out_free) begin
                op_pop   = 1'b1;
                load_out = 1'b1;
                out_next = '{kind: KIND_IDLE, reg_select: 1'b0, nibble: 4'd0,
                             overflow: 1'b0, last: 1'b1};
              end
            end
          endcase
        end
      end
      B_HI: begin
        if (out_free) begin
          load_out   = 1'b1;
          out_next   = '{kind: KIND_NIBBLE, reg_select: rd_data.rs,
                         nibble: rd_data.data[7:4], overflow: 1'b0, last: 1'b0};
          state_next = B_LO;
        end
      end
      B_LO: begin
        if (out_free) begin
          load_out   = 1'b1;
          out_next   = '{kind: KIND_NIBBLE, reg_select: rd_data.rs,
                         nibble: rd_data.data[3:0], overflow: 1'b0, last: 1'b1};
          state_next = B_RUN;
        end
      end
      default: begin
        state_next = B_RUN;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (count <= CNW'(QUEUE_DEPTH)))
    else $error("entry count above queue depth");

  assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == CNW'(QUEUE_DEPTH)) |-> (head == tail))
    else $error("head and tail out of step with count");

  assert property (@(posedge clk) disable iff (rst)
    (state == B_LO) |-> ($past(state) == B_HI || $past(state) == B_LO))
    else $error("low nibble without high nibble");

  assert property (@(posedge clk) disable iff (rst)
    (state != B_RUN) |-> (count < CNW'(QUEUE_DEPTH)))
    else $error("entry sent but queue still full");

endmodule

`default_nettype wire

>>> rtl/core/char_lcd_command_queue_top.sv
`default_nettype none

// channel   direction  handshake               beat payload
// in        input      in_valid / in_stall     in_item  (in_item_t)
// out       output     out_valid / out_stall   out_item (out_item_t)
//
// the front takes a char, command or address item straight from idle; a number item runs
// one divide-by-ten step per digit, then one emit per digit, before the next item is taken
// the back retires one queued op per cycle unless held by out_stall or a sending tick;
// a sending tick runs entry memory read, high nibble, low nibble, so results trail items
// a four-op queue parts front and back; a stalled out_item stalls only the back, and the
// front keeps taking items until the op queue fills; reset empties the queue, not its memory

module char_lcd_command_queue_top import ccq_pkg::*; #(
  parameter int QUEUE_DEPTH = 32,
  parameter int MAX_DIGITS  = 5
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  logic opq_push, opq_full, opq_pop, opq_empty;
  op_t  opq_in, opq_out;

  ccq_front #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .op_push  (opq_push),
    .op_data  (opq_in),
    .op_full  (opq_full)
  );

  ccq_opq u_opq (
    .clk     (clk),
    .rst     (rst),
    .push    (opq_push),
    .push_op (opq_in),
    .full    (opq_full),
    .pop     (opq_pop),
    .pop_op  (opq_out),
    .empty   (opq_empty)
  );

  ccq_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .op        (opq_out),
    .op_empty  (opq_empty),
    .op_pop    (opq_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
